@@ sv/lcdtf_pkg.sv @@
// ----------------------------------------------------------------------------
// lcdtf_pkg
// Shared constants, command codes and types of the text framebuffer refresher.
// ----------------------------------------------------------------------------
package lcdtf_pkg;

    // display and font geometry
    localparam int FRAME_BYTES   = 512;
    localparam int PAGE_WIDTH    = 128;
    localparam int GLYPH_COLUMNS = 12;
    localparam int GLYPH_STRIDE  = 25;
    localparam int FONT_CHARS    = 96;

    localparam int FONT_BYTES  = FONT_CHARS * GLYPH_STRIDE;
    localparam int PAGE_COUNT  = FRAME_BYTES / PAGE_WIDTH;
    localparam int PAGE_SEQ    = 3 + PAGE_WIDTH;
    localparam int GLYPH_BYTES = 2 * GLYPH_COLUMNS;

    // field widths
    localparam int CMD_W    = 3;
    localparam int FONT_AW  = 12;
    localparam int BYTE_W   = 8;
    localparam int ORIGIN_W = 9;

    // internal widths
    localparam int FRAME_AW = $clog2(FRAME_BYTES);
    localparam int CUR_W    = $clog2(FRAME_BYTES + 1);
    localparam int NX_W     = CUR_W + 1;
    localparam int IDX_W    = CUR_W + 2;
    localparam int PAGE_W   = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;
    localparam int OFF_W    = $clog2(PAGE_SEQ);
    localparam int STEP_W   = $clog2(GLYPH_BYTES + 2);

    // command queue
    localparam int OP_DEPTH = 4;
    localparam int OP_AW    = $clog2(OP_DEPTH);
    localparam int OP_CW    = $clog2(OP_DEPTH + 1);

    // command codes on the input
    localparam logic [CMD_W-1:0] CMD_LOAD    = 3'd0;
    localparam logic [CMD_W-1:0] CMD_CHAR1   = 3'd1;
    localparam logic [CMD_W-1:0] CMD_CHAR2   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_CLEAR   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_HOME    = 3'd4;
    localparam logic [CMD_W-1:0] CMD_REFRESH = 3'd5;

    // printable range
    localparam logic [BYTE_W-1:0] CHAR_FIRST = 8'd32;
    localparam logic [BYTE_W-1:0] CHAR_LAST  = 8'd127;

    // display command bytes
    localparam logic [BYTE_W-1:0] LCD_COL_LO    = 8'h00;
    localparam logic [BYTE_W-1:0] LCD_COL_HI    = 8'h10;
    localparam logic [BYTE_W-1:0] LCD_PAGE_BASE = 8'hB0;

    // positions inside one page sequence
    localparam int OFF_COL_LO = 0;
    localparam int OFF_COL_HI = 1;
    localparam int OFF_PAGE   = 2;
    localparam int OFF_DATA   = 3;

    localparam logic [ORIGIN_W-1:0] ORIGIN_RESET = 9'd256;

    typedef enum logic [2:0] {
        OP_LOAD,
        OP_CHAR,
        OP_CLEAR,
        OP_HOME,
        OP_REFRESH
    } t_op_kind;

    typedef struct packed {
        t_op_kind            kind;
        logic                line2;
        logic [FONT_AW-1:0]  addr;   // font address, or glyph base for a character
        logic [BYTE_W-1:0]   data;
    } t_op;

endpackage

@@ sv/lcdtf_front.sv @@
// ----------------------------------------------------------------------------
// lcdtf_front
// Input side: takes items, drops the ones with no effect and turns the rest
// into operations for the command queue.
// ----------------------------------------------------------------------------
module lcdtf_front (
    input  logic                            i_push,
    input  logic                            i_queue_full,
    input  logic                            i_init_busy,
    input  logic [lcdtf_pkg::CMD_W-1:0]     i_cmd,
    input  logic [lcdtf_pkg::FONT_AW-1:0]   i_font_addr,
    input  logic [lcdtf_pkg::BYTE_W-1:0]    i_font_byte,
    input  logic [lcdtf_pkg::BYTE_W-1:0]    i_char_code,
    output logic                            o_full,
    output logic                            o_op_push,
    output lcdtf_pkg::t_op                  o_op
);

    logic                          w_keep;
    logic [lcdtf_pkg::BYTE_W-1:0]  w_glyph;

    assign w_glyph = i_char_code - lcdtf_pkg::CHAR_FIRST;

    always_comb begin
        w_keep     = 1'b0;
        o_op.kind  = lcdtf_pkg::OP_LOAD;
        o_op.line2 = 1'b0;
        o_op.addr  = i_font_addr;
        o_op.data  = i_font_byte;
        unique case (i_cmd)
            lcdtf_pkg::CMD_LOAD: begin
                w_keep = ({1'b0, i_font_addr} < (lcdtf_pkg::FONT_AW + 1)'(lcdtf_pkg::FONT_BYTES));
            end
            lcdtf_pkg::CMD_CHAR1, lcdtf_pkg::CMD_CHAR2: begin
                w_keep     = (i_char_code >= lcdtf_pkg::CHAR_FIRST) &&
                             (i_char_code <= lcdtf_pkg::CHAR_LAST) &&
                             (int'(w_glyph) < lcdtf_pkg::FONT_CHARS);
                o_op.kind  = lcdtf_pkg::OP_CHAR;
                o_op.line2 = (i_cmd == lcdtf_pkg::CMD_CHAR2);
                o_op.addr  = lcdtf_pkg::FONT_AW'(int'(w_glyph) * lcdtf_pkg::GLYPH_STRIDE);
            end
            lcdtf_pkg::CMD_CLEAR: begin
                w_keep    = 1'b1;
                o_op.kind = lcdtf_pkg::OP_CLEAR;
            end
            lcdtf_pkg::CMD_HOME: begin
                w_keep    = 1'b1;
                o_op.kind = lcdtf_pkg::OP_HOME;
            end
            lcdtf_pkg::CMD_REFRESH: begin
                w_keep    = 1'b1;
                o_op.kind = lcdtf_pkg::OP_REFRESH;
            end
            default: begin
                w_keep = 1'b0;
            end
        endcase
    end

    // nothing is taken while the store is being cleared after reset
    assign o_full    = i_queue_full | i_init_busy;
    assign o_op_push = i_push & ~o_full & w_keep;

endmodule

@@ sv/lcdtf_op_fifo.sv @@
// ----------------------------------------------------------------------------
// lcdtf_op_fifo
// Short command queue between the input side and the execution side.
// ----------------------------------------------------------------------------
module lcdtf_op_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  lcdtf_pkg::t_op  i_op,
    input  logic            i_pop,
    output logic            o_full,
    output logic            o_empty,
    output lcdtf_pkg::t_op  o_op
);

    lcdtf_pkg::t_op                  r_mem [lcdtf_pkg::OP_DEPTH];
    logic [lcdtf_pkg::OP_AW-1:0]     r_wr_ptr;
    logic [lcdtf_pkg::OP_AW-1:0]     r_rd_ptr;
    logic [lcdtf_pkg::OP_CW-1:0]     r_count;
    logic                            w_wr;
    logic                            w_rd;

    assign o_full  = (r_count == lcdtf_pkg::OP_CW'(lcdtf_pkg::OP_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_op    = r_mem[r_rd_ptr];
    assign w_wr    = i_push & ~o_full;
    assign w_rd    = i_pop & ~o_empty;

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wr_ptr] <= i_op;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_wr) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_rd) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (w_wr && !w_rd) begin
                r_count <= r_count + 1'b1;
            end else if (w_rd && !w_wr) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

@@ sv/lcdtf_back.sv @@
// ----------------------------------------------------------------------------
// lcdtf_back
// Execution side: font memory, framebuffer, cursors, glyph copy sequencer,
// clearing sweep and the refresh byte stream with its output register.
// ----------------------------------------------------------------------------
module lcdtf_back (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [lcdtf_pkg::ORIGIN_W-1:0]    i_cfg_wdata,
    input  logic                              i_op_valid,
    input  lcdtf_pkg::t_op                    i_op,
    output logic                              o_op_pop,
    output logic                              o_init_busy,
    input  logic                              i_pop,
    output logic                              o_empty,
    output logic [lcdtf_pkg::BYTE_W-1:0]      o_lcd_byte,
    output logic                              o_is_data,
    output logic                              o_frame_end
);

    typedef enum logic [3:0] {
        ST_SWEEP = 4'b0001,
        ST_IDLE  = 4'b0010,
        ST_GLYPH = 4'b0100,
        ST_RFR   = 4'b1000
    } t_state;

    t_state                              r_state;
    logic                                r_init;
    logic [lcdtf_pkg::FRAME_AW-1:0]      r_sweep;
    logic [lcdtf_pkg::ORIGIN_W-1:0]      r_origin;
    logic [lcdtf_pkg::CUR_W-1:0]         r_line1;
    logic [lcdtf_pkg::CUR_W-1:0]         r_line2;
    logic                                r_line2_sel;
    logic [lcdtf_pkg::CUR_W-1:0]         r_cursor;
    logic [lcdtf_pkg::FONT_AW-1:0]       r_base;
    logic [lcdtf_pkg::STEP_W-1:0]        r_step;
    logic [lcdtf_pkg::BYTE_W-1:0]        r_width;
    logic [lcdtf_pkg::PAGE_W-1:0]        r_page;
    logic [lcdtf_pkg::OFF_W-1:0]         r_off;
    logic [lcdtf_pkg::BYTE_W-1:0]        r_rfr_byte;
    logic                                r_rfr_data;
    logic                                r_rfr_end;
    logic                                r_out_valid;
    logic [lcdtf_pkg::BYTE_W-1:0]        r_out_byte;
    logic                                r_out_data;
    logic                                r_out_end;

    logic [lcdtf_pkg::BYTE_W-1:0]        r_font_mem [lcdtf_pkg::FONT_BYTES];
    logic [lcdtf_pkg::BYTE_W-1:0]        r_font_q;
    logic [lcdtf_pkg::BYTE_W-1:0]        r_frame_mem [lcdtf_pkg::FRAME_BYTES];
    logic [lcdtf_pkg::BYTE_W-1:0]        r_frame_q;

    logic                                w_font_we;
    logic [lcdtf_pkg::FONT_AW-1:0]       w_font_raddr;
    logic                                w_frame_we;
    logic [lcdtf_pkg::FRAME_AW-1:0]      w_frame_waddr;
    logic [lcdtf_pkg::BYTE_W-1:0]        w_frame_wdata;
    logic [lcdtf_pkg::FRAME_AW-1:0]      w_frame_raddr;
    logic [lcdtf_pkg::STEP_W-1:0]        w_k;
    logic [lcdtf_pkg::IDX_W-1:0]         w_idx;
    logic [lcdtf_pkg::NX_W-1:0]          w_next_sum;
    logic [lcdtf_pkg::CUR_W-1:0]         w_next_cur;
    logic [lcdtf_pkg::CUR_W-1:0]         w_home_line2;
    logic                                w_take;
    logic                                w_last_step;

    assign o_init_busy = r_init;
    assign o_empty     = ~r_out_valid;
    assign o_lcd_byte  = r_out_byte;
    assign o_is_data   = r_out_data;
    assign o_frame_end = r_out_end;

    // a refresh op waits until the output register has been emptied
    assign w_take   = (r_state == ST_IDLE) && i_op_valid &&
                      ((i_op.kind != lcdtf_pkg::OP_REFRESH) || !r_out_valid);
    assign o_op_pop = w_take;

    // glyph byte k: column k/2, odd bytes go to the page below
    assign w_k   = r_step - lcdtf_pkg::STEP_W'(2);
    assign w_idx = lcdtf_pkg::IDX_W'(r_cursor) + lcdtf_pkg::IDX_W'(w_k >> 1) +
                   (w_k[0] ? lcdtf_pkg::IDX_W'(lcdtf_pkg::PAGE_WIDTH) : '0);
    assign w_last_step = (r_step == lcdtf_pkg::STEP_W'(lcdtf_pkg::GLYPH_BYTES + 1));

    assign w_next_sum = lcdtf_pkg::NX_W'(r_cursor) + lcdtf_pkg::NX_W'(r_width);
    assign w_next_cur = (w_next_sum > lcdtf_pkg::NX_W'(lcdtf_pkg::FRAME_BYTES)) ?
                        lcdtf_pkg::CUR_W'(lcdtf_pkg::FRAME_BYTES) :
                        w_next_sum[lcdtf_pkg::CUR_W-1:0];
    assign w_home_line2 = (int'(r_origin) > lcdtf_pkg::FRAME_BYTES) ?
                          lcdtf_pkg::CUR_W'(lcdtf_pkg::FRAME_BYTES) :
                          lcdtf_pkg::CUR_W'(r_origin);

    assign w_font_we     = w_take && (i_op.kind == lcdtf_pkg::OP_LOAD);
    assign w_font_raddr  = r_base + lcdtf_pkg::FONT_AW'(r_step);
    assign w_frame_raddr = lcdtf_pkg::FRAME_AW'(int'(r_page) * lcdtf_pkg::PAGE_WIDTH +
                                                int'(r_off) - lcdtf_pkg::OFF_DATA);

    always_comb begin
        w_frame_we    = 1'b0;
        w_frame_waddr = r_sweep;
        w_frame_wdata = '0;
        unique case (r_state)
            ST_SWEEP: begin
                w_frame_we = 1'b1;
            end
            ST_GLYPH: begin
                w_frame_we    = (r_step >= lcdtf_pkg::STEP_W'(2)) &&
                                (w_idx < lcdtf_pkg::IDX_W'(lcdtf_pkg::FRAME_BYTES));
                w_frame_waddr = w_idx[lcdtf_pkg::FRAME_AW-1:0];
                w_frame_wdata = r_font_q;
            end
            default: begin
                w_frame_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_font_we) begin
            r_font_mem[i_op.addr] <= i_op.data;
        end
        r_font_q <= r_font_mem[w_font_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (w_frame_we) begin
            r_frame_mem[w_frame_waddr] <= w_frame_wdata;
        end
        r_frame_q <= r_frame_mem[w_frame_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_SWEEP;
            r_init      <= 1'b1;
            r_sweep     <= '0;
            r_origin    <= lcdtf_pkg::ORIGIN_RESET;
            r_line1     <= '0;
            r_line2     <= lcdtf_pkg::CUR_W'(lcdtf_pkg::ORIGIN_RESET);
            r_page      <= '0;
            r_off       <= '0;
            r_out_valid <= 1'b0;
            r_step      <= '0;
        end else begin
            if (i_cfg_we) begin
                r_origin <= i_cfg_wdata;
            end
            if (i_pop && r_out_valid) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_SWEEP: begin
                    if (r_sweep == lcdtf_pkg::FRAME_AW'(lcdtf_pkg::FRAME_BYTES - 1)) begin
                        r_state <= ST_IDLE;
                        r_init  <= 1'b0;
                    end else begin
                        r_sweep <= r_sweep + 1'b1;
                    end
                end
                ST_IDLE: begin
                    if (w_take) begin
                        unique case (i_op.kind)
                            lcdtf_pkg::OP_CHAR: begin
                                r_line2_sel <= i_op.line2;
                                r_cursor    <= i_op.line2 ? r_line2 : r_line1;
                                r_base      <= i_op.addr;
                                r_step      <= '0;
                                r_state     <= ST_GLYPH;
                            end
                            lcdtf_pkg::OP_CLEAR: begin
                                r_line1 <= '0;
                                r_line2 <= '0;
                                r_sweep <= '0;
                                r_state <= ST_SWEEP;
                            end
                            lcdtf_pkg::OP_HOME: begin
                                r_line1 <= '0;
                                r_line2 <= w_home_line2;
                            end
                            lcdtf_pkg::OP_REFRESH: begin
                                priority if (int'(r_off) == lcdtf_pkg::OFF_COL_LO) begin
                                    r_rfr_byte <= lcdtf_pkg::LCD_COL_LO;
                                end else if (int'(r_off) == lcdtf_pkg::OFF_COL_HI) begin
                                    r_rfr_byte <= lcdtf_pkg::LCD_COL_HI;
                                end else if (int'(r_off) == lcdtf_pkg::OFF_PAGE) begin
                                    r_rfr_byte <= lcdtf_pkg::LCD_PAGE_BASE |
                                                  (lcdtf_pkg::BYTE_W'(r_page) & 8'h0F);
                                end else begin
                                    r_rfr_byte <= '0;
                                end
                                r_rfr_data <= (int'(r_off) >= lcdtf_pkg::OFF_DATA);
                                r_rfr_end  <=
                                    (r_page == lcdtf_pkg::PAGE_W'(lcdtf_pkg::PAGE_COUNT - 1)) &&
                                    (r_off == lcdtf_pkg::OFF_W'(lcdtf_pkg::PAGE_SEQ - 1));
                                if (r_off == lcdtf_pkg::OFF_W'(lcdtf_pkg::PAGE_SEQ - 1)) begin
                                    r_off <= '0;
                                    if (r_page == lcdtf_pkg::PAGE_W'(lcdtf_pkg::PAGE_COUNT - 1))
                                    begin
                                        r_page <= '0;
                                    end else begin
                                        r_page <= r_page + 1'b1;
                                    end
                                end else begin
                                    r_off <= r_off + 1'b1;
                                end
                                r_state <= ST_RFR;
                            end
                            default: begin
                                // font load goes straight to the memory
                            end
                        endcase
                    end
                end
                ST_GLYPH: begin
                    if (r_step == lcdtf_pkg::STEP_W'(1)) begin
                        r_width <= r_font_q;
                    end
                    if (w_last_step) begin
                        if (r_line2_sel) begin
                            r_line2 <= w_next_cur;
                        end else begin
                            r_line1 <= w_next_cur;
                        end
                        r_state <= ST_IDLE;
                    end else begin
                        r_step <= r_step + 1'b1;
                    end
                end
                ST_RFR: begin
                    r_out_valid <= 1'b1;
                    r_out_byte  <= r_rfr_data ? r_frame_q : r_rfr_byte;
                    r_out_data  <= r_rfr_data;
                    r_out_end   <= r_rfr_end;
                    r_state     <= ST_IDLE;
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

@@ sv/lcd_text_framebuffer_refresher_top.sv @@
// ----------------------------------------------------------------------------
// lcd_text_framebuffer_refresher_top
// Text framebuffer for a 128x32 page-organised LCD with font rendering and a
// byte-at-a-time refresh stream.
// ----------------------------------------------------------------------------
// After reset the 512-byte framebuffer is swept to zero, one byte a cycle, and
// full stays high until the sweep ends; line_two origin writes are taken
// during that time. Items then go into a four-deep command queue and are
// carried out one at a time by the execution side: items with no effect are
// dropped before the queue, a refresh step first waits for the previous result
// to be popped, a put-char streams the width byte and 24 glyph bytes through
// the font memory read port into the framebuffer write port, and a clear
// sweeps the same framebuffer port. Each refresh step gives one result in the
// output register.
// ----------------------------------------------------------------------------
module lcd_text_framebuffer_refresher_top (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [lcdtf_pkg::ORIGIN_W-1:0]    i_cfg_wdata,
    input  logic                              push,
    output logic                              full,
    input  logic [lcdtf_pkg::CMD_W-1:0]       i_cmd,
    input  logic [lcdtf_pkg::FONT_AW-1:0]     i_font_addr,
    input  logic [lcdtf_pkg::BYTE_W-1:0]      i_font_byte,
    input  logic [lcdtf_pkg::BYTE_W-1:0]      i_char_code,
    output logic                              empty,
    input  logic                              pop,
    output logic [lcdtf_pkg::BYTE_W-1:0]      o_lcd_byte,
    output logic                              o_is_data,
    output logic                              o_frame_end
);

    logic            w_queue_full;
    logic            w_queue_empty;
    logic            w_init_busy;
    logic            w_op_push;
    logic            w_op_pop;
    lcdtf_pkg::t_op  w_op_in;
    lcdtf_pkg::t_op  w_op_head;

    lcdtf_front u_front (
        .i_push       (push),
        .i_queue_full (w_queue_full),
        .i_init_busy  (w_init_busy),
        .i_cmd        (i_cmd),
        .i_font_addr  (i_font_addr),
        .i_font_byte  (i_font_byte),
        .i_char_code  (i_char_code),
        .o_full       (full),
        .o_op_push    (w_op_push),
        .o_op         (w_op_in)
    );

    lcdtf_op_fifo u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_op_push),
        .i_op    (w_op_in),
        .i_pop   (w_op_pop),
        .o_full  (w_queue_full),
        .o_empty (w_queue_empty),
        .o_op    (w_op_head)
    );

    lcdtf_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_op_valid  (~w_queue_empty),
        .i_op        (w_op_head),
        .o_op_pop    (w_op_pop),
        .o_init_busy (w_init_busy),
        .i_pop       (pop),
        .o_empty     (empty),
        .o_lcd_byte  (o_lcd_byte),
        .o_is_data   (o_is_data),
        .o_frame_end (o_frame_end)
    );

    // no transfer reaches the queue while the store is swept after reset
    a_init_queue_empty : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_init_busy |-> w_queue_empty)
        else $error("command queue filled during reset sweep");

    a_pop_only_valid : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_op_pop |-> !w_queue_empty && !w_init_busy)
        else $error("execution side took an op that was not there");

    a_frame_end_data : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && o_frame_end |-> o_is_data)
        else $error("frame end flagged on a command byte");

    a_cmd_byte_legal : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !o_is_data |->
            (o_lcd_byte == lcdtf_pkg::LCD_COL_LO) ||
            (o_lcd_byte == lcdtf_pkg::LCD_COL_HI) ||
            (o_lcd_byte[7:4] == lcdtf_pkg::LCD_PAGE_BASE[7:4]))
        else $error("illegal command byte on the refresh stream");

endmodule

@@ tb/tb_lcd_text_framebuffer_refresher_top.sv @@
// ----------------------------------------------------------------------------
// tb_lcd_text_framebuffer_refresher_top
// Self-checking testbench for the LCD text framebuffer refresher. Font glyph
// records are loaded, characters are drawn on both lines, and refresh steps
// read the display stream back one byte per transfer. A scoreboard keeps its
// own copy of the framebuffer, font memory and cursors and predicts every
// byte. The sender works in bursts, the receiver stalls on its own pattern,
// and the line two origin is rewritten between phases while the block idles.
// ----------------------------------------------------------------------------
module tb_lcd_text_framebuffer_refresher_top;
    import lcdtf_pkg::*;

    localparam logic [CMD_W-1:0] CMD_SPARE_LO = 3'd6;
    localparam logic [CMD_W-1:0] CMD_SPARE_HI = 3'd7;

    localparam int SEQ_LEN       = PAGE_COUNT * PAGE_SEQ;
    localparam int SETTLE_CYCLES = 3000;    // a few clears still queued
    localparam int CYCLE_LIMIT   = 1000000;
    localparam int PHASE_ITEMS   = 385;

    typedef struct packed {
        logic [BYTE_W-1:0] lcd_byte;
        logic              is_data;
        logic              frame_end;
    } lcd_out_t;

    class display_stream_scoreboard;
        bit [BYTE_W-1:0] frame_mem [FRAME_BYTES];
        bit [BYTE_W-1:0] glyph_rom [FONT_BYTES];
        int unsigned     cursor1;
        int unsigned     cursor2;
        int unsigned     stream_pos;
        int unsigned     origin;
        lcd_out_t        expected_bytes [$];
        int              errors;

        function new();
            cursor1    = 0;
            cursor2    = 256;
            stream_pos = 0;
            origin     = ORIGIN_RESET;
            errors     = 0;
        endfunction

        function void set_origin(logic [ORIGIN_W-1:0] value);
            origin = value;
        endfunction

        function int pending();
            return expected_bytes.size();
        endfunction

        // copies one glyph to the two pages at the cursor, returns the new cursor
        function int unsigned draw_glyph(int unsigned cur, logic [BYTE_W-1:0] code);
            int unsigned base;
            int unsigned nxt;
            int unsigned idx;
            if (code < CHAR_FIRST || code > CHAR_LAST)
                return cur;
            if (int'(code - CHAR_FIRST) >= FONT_CHARS)
                return cur;
            base = int'(code - CHAR_FIRST) * GLYPH_STRIDE;
            for (int i = 0; i < GLYPH_COLUMNS; i++) begin
                idx = cur + i;
                if (idx < FRAME_BYTES)
                    frame_mem[idx] = glyph_rom[base + 2 * i + 1];
                idx = cur + i + PAGE_WIDTH;
                if (idx < FRAME_BYTES)
                    frame_mem[idx] = glyph_rom[base + 2 * i + 2];
            end
            nxt = cur + glyph_rom[base];
            return (nxt > FRAME_BYTES) ? FRAME_BYTES : nxt;
        endfunction

        function void note_command(logic [CMD_W-1:0] cmd, logic [FONT_AW-1:0] addr,
                                   logic [BYTE_W-1:0] fbyte, logic [BYTE_W-1:0] code);
            int unsigned pos;
            int unsigned page;
            int unsigned off;
            lcd_out_t    nxt_out;
            case (cmd)
                CMD_LOAD: begin
                    if (addr < FONT_BYTES)
                        glyph_rom[addr] = fbyte;
                end
                CMD_CHAR1: cursor1 = draw_glyph(cursor1, code);
                CMD_CHAR2: cursor2 = draw_glyph(cursor2, code);
                CMD_CLEAR: begin
                    foreach (frame_mem[i])
                        frame_mem[i] = '0;
                    cursor1 = 0;
                    cursor2 = 0;
                end
                CMD_HOME: begin
                    cursor1 = 0;
                    cursor2 = (origin > FRAME_BYTES) ? FRAME_BYTES : origin;
                end
                CMD_REFRESH: begin
                    pos = (stream_pos >= SEQ_LEN) ? 0 : stream_pos;
                    page = pos / PAGE_SEQ;
                    off = pos % PAGE_SEQ;
                    if (off == OFF_COL_LO) begin
                        nxt_out.lcd_byte = LCD_COL_LO;
                        nxt_out.is_data  = 1'b0;
                    end else if (off == OFF_COL_HI) begin
                        nxt_out.lcd_byte = LCD_COL_HI;
                        nxt_out.is_data  = 1'b0;
                    end else if (off == OFF_PAGE) begin
                        nxt_out.lcd_byte = LCD_PAGE_BASE | BYTE_W'(page & 4'hF);
                        nxt_out.is_data  = 1'b0;
                    end else begin
                        nxt_out.lcd_byte = frame_mem[page * PAGE_WIDTH + off - OFF_DATA];
                        nxt_out.is_data  = 1'b1;
                    end
                    nxt_out.frame_end = (pos == SEQ_LEN - 1);
                    stream_pos = (pos + 1 >= SEQ_LEN) ? 0 : pos + 1;
                    expected_bytes.push_back(nxt_out);
                end
                default: ;
            endcase
        endfunction

        function void check_byte(logic [BYTE_W-1:0] lcd_byte, logic is_data, logic frame_end);
            lcd_out_t want;
            if (expected_bytes.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, actual byte %02h data %b end %b",
                         $time, lcd_byte, is_data, frame_end);
                return;
            end
            want = expected_bytes.pop_front();
            if (lcd_byte !== want.lcd_byte) begin
                errors++;
                $display("%0t: lcd_byte mismatch, expected %02h actual %02h",
                         $time, want.lcd_byte, lcd_byte);
            end
            if (is_data !== want.is_data) begin
                errors++;
                $display("%0t: is_data mismatch, expected %b actual %b",
                         $time, want.is_data, is_data);
            end
            if (frame_end !== want.frame_end) begin
                errors++;
                $display("%0t: frame_end mismatch, expected %b actual %b",
                         $time, want.frame_end, frame_end);
            end
        endfunction
    endclass

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_cfg_we    = 1'b0;
    logic [ORIGIN_W-1:0]  i_cfg_wdata = '0;
    logic                 push        = 1'b0;
    logic                 full;
    logic [CMD_W-1:0]     i_cmd       = CMD_LOAD;
    logic [FONT_AW-1:0]   i_font_addr = '0;
    logic [BYTE_W-1:0]    i_font_byte = '0;
    logic [BYTE_W-1:0]    i_char_code = '0;
    logic                 empty;
    logic                 pop         = 1'b0;
    logic [BYTE_W-1:0]    o_lcd_byte;
    logic                 o_is_data;
    logic                 o_frame_end;

    display_stream_scoreboard sb = new();

    int ready_glyphs [$];
    int burst_left  = 0;
    int cycle_count = 0;
    int stall_mode  = 0;
    int mode_left   = 0;

    lcd_text_framebuffer_refresher_top u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .push        (push),
        .full        (full),
        .i_cmd       (i_cmd),
        .i_font_addr (i_font_addr),
        .i_font_byte (i_font_byte),
        .i_char_code (i_char_code),
        .empty       (empty),
        .pop         (pop),
        .o_lcd_byte  (o_lcd_byte),
        .o_is_data   (o_is_data),
        .o_frame_end (o_frame_end)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // receiver: checks each result transfer, stalls in modes of random length
    always @(posedge i_clk) begin
        if (i_rst_n && pop && !empty)
            sb.check_byte(o_lcd_byte, o_is_data, o_frame_end);
        if (mode_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            mode_left  = $urandom_range(20, 200);
        end else begin
            mode_left--;
        end
        case (stall_mode)
            0:       pop <= 1'b1;
            1:       pop <= $urandom_range(0, 1);
            2:       pop <= ($urandom_range(0, 3) != 0);
            default: pop <= ($urandom_range(0, 15) == 0);
        endcase
    end

    task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [FONT_AW-1:0] addr,
                             input logic [BYTE_W-1:0] fbyte, input logic [BYTE_W-1:0] code);
        i_cmd       <= cmd;
        i_font_addr <= addr;
        i_font_byte <= fbyte;
        i_char_code <= code;
        push        <= 1'b1;
        do
            @(posedge i_clk);
        while (full !== 1'b0);
        sb.note_command(cmd, addr, fbyte, code);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            push <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 200)
                                                     : $urandom_range(0, 12);
        end
    endtask

    // command with the unused fields randomised
    task automatic send_ctrl(input logic [CMD_W-1:0] cmd, input logic [BYTE_W-1:0] code);
        send_item(cmd, $urandom_range(0, 4095), $urandom_range(0, 255), code);
    endtask

    task automatic load_glyph(input int glyph, input logic [BYTE_W-1:0] width);
        bit known;
        known = 1'b0;
        send_item(CMD_LOAD, glyph * GLYPH_STRIDE, width, $urandom_range(0, 255));
        for (int k = 1; k < GLYPH_STRIDE; k++)
            send_item(CMD_LOAD, glyph * GLYPH_STRIDE + k, $urandom_range(0, 255),
                      $urandom_range(0, 255));
        foreach (ready_glyphs[i])
            if (ready_glyphs[i] == glyph)
                known = 1'b1;
        if (!known)
            ready_glyphs.push_back(glyph);
    endtask

    function automatic logic [BYTE_W-1:0] pick_width();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel == 0)
            return '0;
        if (sel == 1)
            return 8'hFF;
        if (sel == 2)
            return $urandom_range(0, 255);
        return $urandom_range(6, 14);
    endfunction

    // only glyphs with a complete record are drawn, anything else is unprintable
    function automatic logic [BYTE_W-1:0] pick_char();
        if (ready_glyphs.size() == 0 || $urandom_range(0, 9) == 0)
            return ($urandom_range(0, 1) != 0) ? $urandom_range(0, 31) : $urandom_range(128, 255);
        return CHAR_FIRST + ready_glyphs[$urandom_range(0, ready_glyphs.size() - 1)];
    endfunction

    task automatic wait_drained();
        while (sb.pending() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_origin(input logic [ORIGIN_W-1:0] value);
        push <= 1'b0;
        wait_drained();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sb.set_origin(value);
    endtask

    task automatic random_phase(input int target);
        int               done;
        int               sel;
        int               n;
        logic [CMD_W-1:0] line_cmd;
        logic [BYTE_W-1:0] code;
        done = 0;
        while (done < target) begin
            sel = $urandom_range(0, 99);
            if (sel < 6) begin
                if ($urandom_range(0, 3) == 0)
                    load_glyph(($urandom_range(0, 1) != 0) ? FONT_CHARS - 1 : 0, pick_width());
                else
                    load_glyph($urandom_range(0, FONT_CHARS - 1), pick_width());
                done += GLYPH_STRIDE;
            end else if (sel < 46) begin
                // a line of text, often from the start of the line
                line_cmd = ($urandom_range(0, 1) != 0) ? CMD_CHAR2 : CMD_CHAR1;
                if ($urandom_range(0, 3) == 0) begin
                    send_ctrl(CMD_HOME, $urandom_range(0, 255));
                    done++;
                end
                n = $urandom_range(1, 8);
                repeat (n) begin
                    code = pick_char();
                    send_ctrl(line_cmd, code);
                    if (code >= CHAR_FIRST && code <= CHAR_LAST)
                        done++;
                end
            end else if (sel < 71) begin
                n = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 30);
                repeat (n) send_ctrl(CMD_REFRESH, $urandom_range(0, 255));
                done += n;
            end else begin
                case ($urandom_range(0, 5))
                    0, 1: begin
                        send_item(CMD_LOAD, $urandom_range(0, 4095), $urandom_range(0, 255),
                                  $urandom_range(0, 255));
                        done++;
                    end
                    2: begin
                        send_ctrl(CMD_HOME, $urandom_range(0, 255));
                        done++;
                    end
                    3: begin
                        send_ctrl(CMD_CLEAR, $urandom_range(0, 255));
                        done++;
                    end
                    default: send_ctrl(($urandom_range(0, 1) != 0) ? CMD_SPARE_HI : CMD_SPARE_LO,
                                       $urandom_range(0, 255));
                endcase
            end
        end
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed part, origin still at its reset value
        load_glyph(0, 8'd12);
        load_glyph(FONT_CHARS - 1, 8'hFF);
        send_ctrl(CMD_REFRESH, 8'hFF);
        send_ctrl(CMD_CHAR1, CHAR_FIRST);
        send_ctrl(CMD_CHAR2, CHAR_LAST);          // line two runs to the last byte
        send_ctrl(CMD_CHAR2, CHAR_LAST);          // lower page dropped, cursor saturates
        send_ctrl(CMD_CHAR1, CHAR_LAST);
        send_ctrl(CMD_CHAR1, CHAR_LAST);
        send_ctrl(CMD_CHAR1, CHAR_FIRST);         // whole glyph off the end
        send_ctrl(CMD_CHAR1, CHAR_FIRST - 1);
        send_ctrl(CMD_CHAR1, CHAR_LAST + 1);
        send_ctrl(CMD_CHAR2, 8'h00);
        send_ctrl(CMD_CHAR2, 8'hFF);
        send_item(CMD_SPARE_LO, '1, '1, '1);
        send_item(CMD_SPARE_HI, '0, '0, '0);
        send_ctrl(CMD_HOME, 8'h00);
        send_ctrl(CMD_CHAR2, CHAR_FIRST);
        send_item(CMD_LOAD, '1, 8'hFF, 8'hFF);    // beyond font memory, ignored
        send_item(CMD_LOAD, FONT_BYTES, 8'h5A, 8'h00);
        repeat (3) send_ctrl(CMD_REFRESH, 8'h00);
        send_ctrl(CMD_CLEAR, 8'h00);
        send_ctrl(CMD_REFRESH, 8'h00);
        send_ctrl(CMD_HOME, 8'h00);

        write_origin('1);
        random_phase(PHASE_ITEMS);
        write_origin('0);
        random_phase(PHASE_ITEMS);
        write_origin($urandom_range(0, 511));
        random_phase(PHASE_ITEMS);
        write_origin(ORIGIN_RESET);
        random_phase(PHASE_ITEMS);
        write_origin($urandom_range(0, 511));
        random_phase(PHASE_ITEMS);

        push <= 1'b0;
        wait_drained();
        if (sb.errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
